@@ rtl/bws_pkg.sv @@
// shared types, codes and constants of the battery window scheduler
`default_nettype none

package bws_pkg;

	// result word codes
	typedef enum logic [1:0] {
		ACT_NONE    = 2'd0,
		ACT_DISABLE = 2'd1,
		ACT_ENABLE  = 2'd2
	} act_t;

	// register indexes on the config port
	localparam logic [2:0] REG_SCHED_ENABLE    = 3'd0;
	localparam logic [2:0] REG_WINDOW_START    = 3'd1;
	localparam logic [2:0] REG_WINDOW_END      = 3'd2;
	localparam logic [2:0] REG_CHARGE_STOP     = 3'd3;
	localparam logic [2:0] REG_CHARGE_RECOVERY = 3'd4;
	localparam logic [2:0] REG_ZONE_OFFSET     = 3'd5;

	localparam int ADDR_W = 5;
	localparam int DATA_W = 32;

	// reset values
	localparam logic [9:0] CHARGE_STOP_RST     = 10'd100;
	localparam logic [9:0] CHARGE_RECOVERY_RST = 10'd200;

	// epoch / 60 as multiply and shift, exact over all 32-bit inputs
	localparam logic [31:0] DIV60_MAGIC = 32'h8888_8889;
	localparam int          DIV60_SHIFT = 37;
	localparam int          MIN_W       = 27;

	// minutes / 1440 as (minutes >> 5) / 45, exact below 2^22
	localparam int          DIV45_PRE   = 5;
	localparam logic [26:0] DIV45_MAGIC = 27'd95443718;
	localparam int          DIV45_SHIFT = 32;
	localparam int          DAY_W       = 17;

	localparam logic [10:0] MINUTES_PER_DAY = 11'd1440;

	// queue between front and back, power of two deep
	localparam int FIFO_DEPTH = 4;
	localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
	localparam int FIFO_CW    = $clog2(FIFO_DEPTH + 1);

	typedef struct packed {
		logic               sched_enable;
		logic        [10:0] window_start;
		logic        [10:0] window_end;
		logic        [9:0]  charge_stop;
		logic        [9:0]  charge_recovery;
		logic signed [10:0] zone_offset;
	} cfg_t;

	// classified tick handed from front to back
	typedef struct packed {
		logic trip;
		logic ready;
		logic epoch_zero;
		logic in_win;
	} cls_t;

endpackage

`default_nettype wire

@@ rtl/battery_window_scheduler_core.sv @@
// top level of the battery window scheduler
// path: an accepted word passes front stages s1, s2 and s3, the queue and the output register to give its action word
// throughput: one word per cycle while not stalled, set by the three-stage front pipeline and one-word back step
// the front and back are parted by a four-entry queue, so either side stalls on its own
// reset: arst_n clears window state, queue and valid flags at once and loads register defaults
`default_nettype none

module battery_window_scheduler_core (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        psel,
	input  wire logic                        penable,
	input  wire logic                        pwrite,
	input  wire logic [bws_pkg::ADDR_W-1:0]  paddr,
	input  wire logic [bws_pkg::DATA_W-1:0]  pwdata,
	output logic      [bws_pkg::DATA_W-1:0]  prdata,
	output logic                             pready,
	input  wire logic                        in_valid,
	output logic                             in_stall,
	input  wire logic [31:0]                 epoch_seconds,
	input  wire logic [9:0]                  charge_level,
	input  wire logic signed [15:0]          active_power,
	input  wire logic                        is_running,
	input  wire logic                        has_fault,
	input  wire logic                        link_lost,
	output logic                             out_valid,
	input  wire logic                        out_stall,
	output logic [1:0]                       action
);

	bws_pkg::cfg_t cfg;
	bws_pkg::cls_t cls_in, cls_head;
	logic          push, pop, fifo_full, fifo_empty;

	bws_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	bws_front u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg           (cfg),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.epoch_seconds (epoch_seconds),
		.charge_level  (charge_level),
		.active_power  (active_power),
		.is_running    (is_running),
		.has_fault     (has_fault),
		.link_lost     (link_lost),
		.fifo_full     (fifo_full),
		.push          (push),
		.cls           (cls_in)
	);

	bws_fifo u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.wdata  (cls_in),
		.full   (fifo_full),
		.pop    (pop),
		.rdata  (cls_head),
		.empty  (fifo_empty)
	);

	bws_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.sched_enable (cfg.sched_enable),
		.fifo_empty   (fifo_empty),
		.head         (cls_head),
		.pop          (pop),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.action       (action)
	);

endmodule

`default_nettype wire

@@ rtl/bws_cfg.sv @@
// configuration registers behind the apb-style port
`default_nettype none

module bws_cfg (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         psel,
	input  wire logic                         penable,
	input  wire logic                         pwrite,
	input  wire logic [bws_pkg::ADDR_W-1:0]   paddr,
	input  wire logic [bws_pkg::DATA_W-1:0]   pwdata,
	output logic      [bws_pkg::DATA_W-1:0]   prdata,
	output logic                              pready,
	output bws_pkg::cfg_t                     cfg
);

	bws_pkg::cfg_t cfg_q;
	logic [2:0]    idx;
	logic          wr_en;

	assign idx    = paddr[4:2];
	assign wr_en  = psel && penable && pwrite;
	assign pready = 1'b1;
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.sched_enable    <= 1'b0;
			cfg_q.window_start    <= '0;
			cfg_q.window_end      <= '0;
			cfg_q.charge_stop     <= bws_pkg::CHARGE_STOP_RST;
			cfg_q.charge_recovery <= bws_pkg::CHARGE_RECOVERY_RST;
			cfg_q.zone_offset     <= '0;
		end else if (wr_en) begin
			unique case (idx)
				bws_pkg::REG_SCHED_ENABLE:    cfg_q.sched_enable    <= pwdata[0];
				bws_pkg::REG_WINDOW_START:    cfg_q.window_start    <= pwdata[10:0];
				bws_pkg::REG_WINDOW_END:      cfg_q.window_end      <= pwdata[10:0];
				bws_pkg::REG_CHARGE_STOP:     cfg_q.charge_stop     <= pwdata[9:0];
				bws_pkg::REG_CHARGE_RECOVERY: cfg_q.charge_recovery <= pwdata[9:0];
				bws_pkg::REG_ZONE_OFFSET:     cfg_q.zone_offset     <= $signed(pwdata[10:0]);
				default: ;
			endcase
		end
	end

	always_comb begin
		prdata = '0;
		unique case (idx)
			bws_pkg::REG_SCHED_ENABLE:    prdata[0]    = cfg_q.sched_enable;
			bws_pkg::REG_WINDOW_START:    prdata[10:0] = cfg_q.window_start;
			bws_pkg::REG_WINDOW_END:      prdata[10:0] = cfg_q.window_end;
			bws_pkg::REG_CHARGE_STOP:     prdata[9:0]  = cfg_q.charge_stop;
			bws_pkg::REG_CHARGE_RECOVERY: prdata[9:0]  = cfg_q.charge_recovery;
			bws_pkg::REG_ZONE_OFFSET:     prdata       = 32'($signed(cfg_q.zone_offset));
			default: ;
		endcase
	end

endmodule

`default_nettype wire

@@ rtl/bws_front.sv @@
// front pipeline: takes input words, finds local minute of day and classifies each tick
`default_nettype none

module bws_front (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire bws_pkg::cfg_t       cfg,
	input  wire logic                in_valid,
	output logic                     in_stall,
	input  wire logic [31:0]         epoch_seconds,
	input  wire logic [9:0]          charge_level,
	input  wire logic signed [15:0]  active_power,
	input  wire logic                is_running,
	input  wire logic                has_fault,
	input  wire logic                link_lost,
	input  wire logic                fifo_full,
	output logic                     push,
	output bws_pkg::cls_t            cls
);

	localparam logic signed [12:0] DAY_MIN_S = $signed({2'b00, bws_pkg::MINUTES_PER_DAY});

	logic advance;

	logic v_s1, v_s2, v_s3;

	logic [bws_pkg::MIN_W-1:0] mins_s1;
	logic                      trip_s1, ready_s1, ezero_s1;

	logic [10:0]               qlo_s2;
	logic [bws_pkg::DAY_W-1:0] days_s2;
	logic                      trip_s2, ready_s2, ezero_s2;

	logic [10:0]               m_s3;
	logic                      trip_s3, ready_s3, ezero_s3;

	logic [63:0]        prod60;
	logic [48:0]        prod45;
	logic [10:0]        m_utc;
	logic signed [12:0] zone_ext;
	logic signed [12:0] sum;
	logic [10:0]        minute;
	logic               win;

	// whole pipeline holds while the last stage cannot enter the queue
	assign advance  = !(v_s3 && fifo_full);
	assign in_stall = !advance;
	assign push     = v_s3 && !fifo_full;

	assign prod60 = epoch_seconds * bws_pkg::DIV60_MAGIC;
	assign prod45 = mins_s1[bws_pkg::MIN_W-1:bws_pkg::DIV45_PRE] * bws_pkg::DIV45_MAGIC;
	// minutes mod 1440, only the low bits matter since the result is below 2048
	assign m_utc  = qlo_s2 - 11'(days_s2 * bws_pkg::MINUTES_PER_DAY);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else if (advance) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			mins_s1  <= prod60[bws_pkg::DIV60_SHIFT +: bws_pkg::MIN_W];
			trip_s1  <= (active_power > 16'sd0) && is_running
				&& (charge_level <= cfg.charge_stop);
			ready_s1 <= (charge_level >= cfg.charge_recovery) && !has_fault && !link_lost;
			ezero_s1 <= (epoch_seconds == 32'd0);

			qlo_s2   <= mins_s1[10:0];
			days_s2  <= prod45[bws_pkg::DIV45_SHIFT +: bws_pkg::DAY_W];
			trip_s2  <= trip_s1;
			ready_s2 <= ready_s1;
			ezero_s2 <= ezero_s1;

			m_s3     <= m_utc;
			trip_s3  <= trip_s2;
			ready_s3 <= ready_s2;
			ezero_s3 <= ezero_s2;
		end
	end

	// shift by the zone offset and wrap into one day
	always_comb begin
		zone_ext = {{2{cfg.zone_offset[10]}}, cfg.zone_offset};
		sum      = $signed({2'b00, m_s3}) + zone_ext;
		if (sum < 13'sd0) begin
			minute = 11'(sum + DAY_MIN_S);
		end else if (sum >= DAY_MIN_S) begin
			minute = 11'(sum - DAY_MIN_S);
		end else begin
			minute = 11'(sum);
		end
	end

	// window may wrap past midnight, equal bounds never match
	always_comb begin
		if (cfg.window_start == cfg.window_end) begin
			win = 1'b0;
		end else if (cfg.window_start < cfg.window_end) begin
			win = (minute >= cfg.window_start) && (minute < cfg.window_end);
		end else begin
			win = (minute >= cfg.window_start) || (minute < cfg.window_end);
		end
	end

	assign cls.trip       = trip_s3;
	assign cls.ready      = ready_s3;
	assign cls.epoch_zero = ezero_s3;
	assign cls.in_win     = win;

endmodule

`default_nettype wire

@@ rtl/bws_fifo.sv @@
// short queue of classified ticks between front and back
`default_nettype none

module bws_fifo (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          push,
	input  wire bws_pkg::cls_t wdata,
	output logic               full,
	input  wire logic          pop,
	output bws_pkg::cls_t      rdata,
	output logic               empty
);

	bws_pkg::cls_t                entry_q [bws_pkg::FIFO_DEPTH];
	logic [bws_pkg::FIFO_AW-1:0]  wr_ptr_q, rd_ptr_q;
	logic [bws_pkg::FIFO_CW-1:0]  cnt_q;

	assign full  = (cnt_q == bws_pkg::FIFO_CW'(bws_pkg::FIFO_DEPTH));
	assign empty = (cnt_q == '0);
	assign rdata = entry_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			unique case ({push, pop})
				2'b10:   cnt_q <= cnt_q + 1'b1;
				2'b01:   cnt_q <= cnt_q - 1'b1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= wdata;
		end
	end

endmodule

`default_nettype wire

@@ rtl/bws_back.sv @@
// back end: window state, action decision and output register
`default_nettype none

module bws_back (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          sched_enable,
	input  wire logic          fifo_empty,
	input  wire bws_pkg::cls_t head,
	output logic               pop,
	output logic               out_valid,
	input  wire logic          out_stall,
	output logic [1:0]         action
);

	logic           seen_q, was_q, pend_q, out_valid_q;
	bws_pkg::act_t  act_q;

	logic           seen_d, was_d, pend_d;
	bws_pkg::act_t  act_d;
	logic           was;

	// take a new word whenever the output register is free or being emptied
	assign pop       = !fifo_empty && (!out_valid_q || !out_stall);
	assign out_valid = out_valid_q;
	assign action    = act_q;
	assign was       = seen_q && was_q;

	always_comb begin
		seen_d = seen_q;
		was_d  = was_q;
		pend_d = pend_q;
		act_d  = bws_pkg::ACT_NONE;
		priority if (head.trip) begin
			act_d  = bws_pkg::ACT_DISABLE;
			pend_d = 1'b0;
		end else if (!sched_enable) begin
			seen_d = 1'b0;
			was_d  = 1'b0;
			pend_d = 1'b0;
		end else if (head.epoch_zero) begin
			// time not synced, state untouched
		end else begin
			if (head.in_win && !was) begin
				if (head.ready) begin
					act_d  = bws_pkg::ACT_ENABLE;
					pend_d = 1'b0;
				end else begin
					pend_d = 1'b1;
				end
			end else if (!head.in_win && was) begin
				act_d  = bws_pkg::ACT_DISABLE;
				pend_d = 1'b0;
			end else if (head.in_win && pend_q && head.ready) begin
				act_d  = bws_pkg::ACT_ENABLE;
				pend_d = 1'b0;
			end
			was_d  = head.in_win;
			seen_d = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seen_q      <= 1'b0;
			was_q       <= 1'b0;
			pend_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (pop) begin
				seen_q <= seen_d;
				was_q  <= was_d;
				pend_q <= pend_d;
			end
			if (pop) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			act_q <= act_d;
		end
	end

`ifndef SYNTH
	// a pending retry only exists inside a tracked window
	assert property (@(posedge clk) disable iff (!arst_n) pend_q |-> seen_q)
		else $error("enable pending without seen state");

	// a held result is never overwritten
	assert property (@(posedge clk) disable iff (!arst_n) !(pop && out_valid_q && out_stall))
		else $error("queue popped while output word stalled");

	// protection trip always gives disable
	assert property (@(posedge clk) disable iff (!arst_n)
		(pop && head.trip) |=> (act_q == bws_pkg::ACT_DISABLE))
		else $error("protection trip did not disable");
`endif

endmodule

`default_nettype wire
